// ----- hdl/rcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared codes, command word and result word of the completion fence.
// ----------------------------------------------------------------------------
package rcf_pkg;

    localparam int GEN_W   = 64;
    localparam int OWNER_W = 32;
    localparam int ERR_W   = 15;
    localparam int Q_DEPTH = 2;

    localparam logic [2:0] REQ_QUERY  = 3'd0;
    localparam logic [2:0] REQ_WAIT   = 3'd1;
    localparam logic [2:0] REQ_RESET  = 3'd2;
    localparam logic [2:0] REQ_BIND   = 3'd3;
    localparam logic [2:0] REQ_ADMIT  = 3'd4;
    localparam logic [2:0] REQ_UNBIND = 3'd5;
    localparam logic [2:0] REQ_SIGNAL = 3'd6;
    localparam logic [2:0] REQ_DEVICE = 3'd7;

    localparam logic [3:0] OC_OK         = 4'd0;
    localparam logic [3:0] OC_INVALID    = 4'd1;
    localparam logic [3:0] OC_STALE      = 4'd2;
    localparam logic [3:0] OC_BUSY       = 4'd3;
    localparam logic [3:0] OC_NOPERM     = 4'd4;
    localparam logic [3:0] OC_OVERFLOW   = 4'd5;
    localparam logic [3:0] OC_WOULDBLOCK = 4'd6;
    localparam logic [3:0] OC_XDEV       = 4'd7;
    localparam logic [3:0] OC_PENDING    = 4'd8;

    localparam logic [1:0] PH_PENDING  = 2'd0;
    localparam logic [1:0] PH_SIGNALED = 2'd1;
    localparam logic [1:0] PH_ERROR    = 2'd2;

    localparam logic CFG_DEVICE_ID      = 1'b0;
    localparam logic CFG_START_SIGNALED = 1'b1;

    typedef struct packed {
        logic [2:0]         kind;
        logic [GEN_W-1:0]   gen;
        logic               gen_zero;
        logic [OWNER_W-1:0] owner;
        logic               owner_zero;
        logic               sneg;
        logic [ERR_W-1:0]   serr;
        logic               imm;
        logic               work;
        logic               dev_match;
    } t_cmd;

    typedef struct packed {
        logic [3:0]       outcome;
        logic [GEN_W-1:0] snap_generation;
        logic [1:0]       snap_state;
        logic [ERR_W-1:0] snap_error;
        logic             ready_res;
        logic             failed;
    } t_res;

    typedef struct packed {
        logic recreate;
        logic start_signaled;
    } t_cfg_ctl;

endpackage
`default_nettype wire

// ----- hdl/rcf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_in_if / rcf_out_if
// Request and result channels of the completion fence.
// ----------------------------------------------------------------------------
interface rcf_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [63:0]        req_generation;
    logic [31:0]        owner_id;
    logic signed [15:0] signal_status;
    logic               immediate;
    logic               work_wait;
    logic [63:0]        check_device;

    modport source (
        output valid, req_type, req_generation, owner_id, signal_status,
               immediate, work_wait, check_device,
        input  ready
    );
    modport sink (
        input  valid, req_type, req_generation, owner_id, signal_status,
               immediate, work_wait, check_device,
        output ready
    );
endinterface

interface rcf_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  outcome;
    logic [63:0] snap_generation;
    logic [1:0]  snap_state;
    logic [14:0] snap_error;
    logic        ready_res;
    logic        failed;

    modport source (
        output valid, outcome, snap_generation, snap_state, snap_error,
               ready_res, failed,
        input  ready
    );
    modport sink (
        input  valid, outcome, snap_generation, snap_state, snap_error,
               ready_res, failed,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/rcf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_front
// Accepts request words, classifies them into command words and holds the
// configuration registers.
// ----------------------------------------------------------------------------
module rcf_front #(
    parameter int OWNER_BITS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    rcf_in_if.sink                i_req,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_idx,
    input  wire  [63:0]           i_cfg_wdata,
    input  wire                   i_q_full,
    output logic                  o_push,
    output rcf_pkg::t_cmd         o_cmd,
    output rcf_pkg::t_cfg_ctl     o_cfg
);
    import rcf_pkg::*;

    localparam int OWN_W = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;
    localparam logic [OWNER_W-1:0] OWN_MASK =
        (OWN_W == OWNER_W) ? {OWNER_W{1'b1}}
                           : OWNER_W'((64'd1 << OWN_W) - 64'd1);

    logic [63:0]        r_device_id;
    logic               r_start_signaled;
    logic               r_recreate;
    logic [OWNER_W-1:0] owner_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id      <= 64'd1;
            r_start_signaled <= 1'b0;
            r_recreate       <= 1'b0;
        end else begin
            r_recreate <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEVICE_ID:      r_device_id      <= i_cfg_wdata;
                    CFG_START_SIGNALED: r_start_signaled <= i_cfg_wdata[0];
                endcase
            end
        end
    end

    assign owner_m = i_req.owner_id & OWN_MASK;

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

    always_comb begin
        o_cmd.kind       = i_req.req_type;
        o_cmd.gen        = i_req.req_generation;
        o_cmd.gen_zero   = (i_req.req_generation == '0);
        o_cmd.owner      = owner_m;
        o_cmd.owner_zero = (owner_m == '0);
        o_cmd.sneg       = i_req.signal_status[15];
        o_cmd.serr       = i_req.signal_status[ERR_W-1:0];
        o_cmd.imm        = i_req.immediate;
        o_cmd.work       = i_req.work_wait;
        o_cmd.dev_match  = (i_req.check_device == r_device_id);
    end

    assign o_cfg.recreate       = r_recreate;
    assign o_cfg.start_signaled = r_start_signaled;

endmodule
`default_nettype wire

// ----- hdl/rcf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_queue
// Two-entry queue of command words between front and back.
// ----------------------------------------------------------------------------
module rcf_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  rcf_pkg::t_cmd      i_data,
    input  wire                i_pop,
    output logic               o_full,
    output logic               o_empty,
    output rcf_pkg::t_cmd      o_data
);
    import rcf_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

endmodule
`default_nettype wire

// ----- hdl/rcf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcf_back
// Executes command words against the fence record and registers the result.
// ----------------------------------------------------------------------------
module rcf_back #(
    parameter int OWNER_BITS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  rcf_pkg::t_cfg_ctl     i_cfg,
    input  wire                   i_q_empty,
    input  rcf_pkg::t_cmd         i_cmd,
    output logic                  o_pop,
    rcf_out_if.source             o_res
);
    import rcf_pkg::*;

    localparam int OWN_W = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;

    logic [GEN_W-1:0] r_gen,      n_gen;
    logic [1:0]       r_phase,    n_phase;
    logic [OWN_W-1:0] r_owner,    n_owner;
    logic             r_admitted, n_admitted;
    logic [ERR_W-1:0] r_err,      n_err;
    t_res             r_res,      n_res;
    logic             r_out_valid;

    logic             same;
    logic             pending;
    logic             owner_ok;
    logic             snap;
    logic [3:0]       oc;

    assign o_pop = !i_q_empty && (!r_out_valid || o_res.ready);

    assign same     = (i_cmd.gen == r_gen);
    assign pending  = (r_phase == PH_PENDING);
    assign owner_ok = !i_cmd.owner_zero && (r_owner == i_cmd.owner[OWN_W-1:0]);

    always_comb begin
        n_gen      = r_gen;
        n_phase    = r_phase;
        n_owner    = r_owner;
        n_admitted = r_admitted;
        n_err      = r_err;
        oc         = OC_OK;
        snap       = 1'b0;
        unique case (i_cmd.kind)
            REQ_QUERY: begin
                if (!i_cmd.gen_zero && !same) oc = OC_STALE;
                else snap = 1'b1;
            end
            REQ_WAIT: begin
                if (i_cmd.gen_zero) oc = OC_INVALID;
                else if (same && pending) begin
                    oc = ((i_cmd.work && !r_admitted) || i_cmd.imm) ? OC_WOULDBLOCK
                                                                    : OC_PENDING;
                end else if (!same) oc = OC_STALE;
                else snap = 1'b1;
            end
            REQ_RESET: begin
                if (i_cmd.gen_zero) oc = OC_INVALID;
                else if (!same) oc = OC_STALE;
                else if (r_owner != '0) oc = OC_BUSY;
                else if (r_gen == '1) oc = OC_OVERFLOW;
                else begin
                    n_gen      = r_gen + GEN_W'(1);
                    n_phase    = PH_PENDING;
                    n_admitted = 1'b0;
                    n_err      = '0;
                    snap       = 1'b1;
                end
            end
            REQ_BIND: begin
                if (i_cmd.owner_zero || i_cmd.gen_zero) oc = OC_INVALID;
                else if (!same) oc = OC_STALE;
                else if (!pending || r_owner != '0) oc = OC_BUSY;
                else begin
                    n_owner    = i_cmd.owner[OWN_W-1:0];
                    n_admitted = 1'b0;
                end
            end
            REQ_ADMIT: begin
                if (!same) oc = OC_STALE;
                else if (!owner_ok) oc = OC_NOPERM;
                else if (!pending) oc = OC_INVALID;
                else n_admitted = 1'b1;
            end
            REQ_UNBIND: begin
                if (!same) oc = OC_STALE;
                else if (!owner_ok) oc = OC_NOPERM;
                else begin
                    n_owner    = '0;
                    n_admitted = 1'b0;
                end
            end
            REQ_SIGNAL: begin
                if (i_cmd.sneg) oc = OC_INVALID;
                else if (!same) oc = OC_STALE;
                else if (!owner_ok) oc = OC_NOPERM;
                else begin
                    n_phase    = (i_cmd.serr != '0) ? PH_ERROR : PH_SIGNALED;
                    n_err      = i_cmd.serr;
                    n_owner    = '0;
                    n_admitted = 1'b0;
                end
            end
            REQ_DEVICE: begin
                if (!i_cmd.dev_match) oc = OC_XDEV;
            end
        endcase

        n_res.outcome         = oc;
        n_res.snap_generation = snap ? n_gen : '0;
        n_res.snap_state      = snap ? n_phase : '0;
        n_res.snap_error      = snap ? n_err : '0;
        n_res.ready_res       = (n_phase != PH_PENDING);
        n_res.failed          = (n_phase == PH_ERROR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen       <= GEN_W'(1);
            r_phase     <= PH_PENDING;
            r_owner     <= '0;
            r_admitted  <= 1'b0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.recreate) begin
                r_gen      <= GEN_W'(1);
                r_phase    <= i_cfg.start_signaled ? PH_SIGNALED : PH_PENDING;
                r_owner    <= '0;
                r_admitted <= 1'b0;
                r_err      <= '0;
            end else if (o_pop) begin
                r_gen      <= n_gen;
                r_phase    <= n_phase;
                r_owner    <= n_owner;
                r_admitted <= n_admitted;
                r_err      <= n_err;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.outcome         = r_res.outcome;
    assign o_res.snap_generation = r_res.snap_generation;
    assign o_res.snap_state      = r_res.snap_state;
    assign o_res.snap_error      = r_res.snap_error;
    assign o_res.ready_res       = r_res.ready_res;
    assign o_res.failed          = r_res.failed;

`ifndef SYNTHESIS
    a_recreate_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.recreate |=> (r_gen == GEN_W'(1)))
        else $error("generation not restarted after re-creation");

    a_owner_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_owner != '0) |-> (r_phase == PH_PENDING))
        else $error("owner bound while fence not pending");

    a_admit_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_admitted |-> (r_owner != '0))
        else $error("admitted without bound owner");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("executed word produced no result");
`endif

endmodule
`default_nettype wire

// ----- hdl/resettable_completion_fence.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resettable_completion_fence
// One completion fence: front decode, two-entry command queue, back execute.
//
//   channel  dir  handshake          payload
//   i_req    in   valid/ready        request word
//   o_res    out  valid/ready        result word
//   i_cfg_*  in   write enable only  register index, write data
//
// One request per cycle sustained while results are taken; an accepted request
// is written to the command queue, then registered as the result word.
// Input ready depends only on the command queue fill, not on the result side.
// Back stalls when the result register holds an untaken word.
// Synchronous active-low reset; a register write re-creates the fence through
// the registered recreate strobe.
// ----------------------------------------------------------------------------
module resettable_completion_fence #(
    parameter int OWNER_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rcf_in_if.sink      i_req,
    rcf_out_if.source   o_res,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [63:0] i_cfg_wdata
);
    import rcf_pkg::*;

    t_cmd     push_cmd;
    t_cmd     head_cmd;
    t_cfg_ctl cfg_ctl;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;

    rcf_front #(
        .OWNER_BITS (OWNER_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_cfg       (cfg_ctl)
    );

    rcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (head_cmd)
    );

    rcf_back #(
        .OWNER_BITS (OWNER_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_ctl),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire
